[sv/bcl_pkg.sv]
// ----------------------------------------------------------------------------
// bcl_pkg
// Shared types and constants for the LRU block cache tag table.
// ----------------------------------------------------------------------------
package bcl_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int TAG_BITS_DEF = 32;
   localparam int BLOCK_W      = 32;
   localparam int THR_W        = 7;
   localparam logic [THR_W-1:0] THR_RESET = 7'd32;

   typedef enum logic [1:0] {
      REQ_ACQUIRE,
      REQ_RELEASE,
      REQ_PIN,
      REQ_UNPIN
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_NO_SLOT,
      STATUS_NOT_CACHED
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOOK,
      S_HIT_UPD,
      S_ORDER,
      S_WALK,
      S_COMPACT,
      S_FREE,
      S_INC,
      S_INSERT,
      S_DONE
   } state_type;

endpackage

[sv/bcl_ram.sv]
// ----------------------------------------------------------------------------
// bcl_ram
// Simple dual-port RAM: one write port with bit mask, one registered read.
// ----------------------------------------------------------------------------
module bcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [WIDTH-1:0]         wr_mask,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // masked write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= (mem[wr_addr] & ~wr_mask) | (wr_data & wr_mask);
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/block_cache_lru_evict.sv]
// ----------------------------------------------------------------------------
// block_cache_lru_evict
// LRU tag table of cached disk blocks with pin / acquire protection.
// ----------------------------------------------------------------------------
// One request at a time. Lookup sweeps the entry RAM; a hit acquire adds a rank
//   sweep; a miss adds a free-slot search and an increment sweep, or, when at
//   threshold, order build + walk + compaction and then the free-slot search.
// Throughput is set by the single read port of the entry RAM.
// Reset: synchronous; clears valid/acquired/pinned bits, count, threshold=32.
// ----------------------------------------------------------------------------
module block_cache_lru_evict
   import bcl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int TAG_BITS = TAG_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_type,
   input  logic [BLOCK_W-1:0]             req_block_no,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_hit,
   output logic [$clog2(CAPACITY)-1:0]    rsp_slot,
   output logic                           rsp_fetch_needed,
   output logic [$clog2(CAPACITY+1)-1:0]  rsp_evicted_count,
   output logic [$clog2(CAPACITY+1)-1:0]  rsp_cached_count,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_wr_en,
   input  logic [THR_W-1:0]               csr_wr_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
   localparam int EW    = TAG_BITS + IDX_W;
   localparam int XW    = TAG_BITS + BLOCK_W;
   localparam logic [EW-1:0]    RANK_MASK = {{TAG_BITS{1'b0}}, {IDX_W{1'b1}}};
   localparam logic [EW-1:0]    FULL_MASK = {EW{1'b1}};
   localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);

   // state
   state_type             state_ff, state_in;
   logic [THR_W-1:0]      thr_ff;
   logic [CAPACITY-1:0]   valid_ff, valid_in;
   logic [CAPACITY-1:0]   acq_ff, acq_in;
   logic [CAPACITY-1:0]   pin_ff, pin_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   // working registers
   req_kind_type          kind_ff, kind_in;
   logic [TAG_BITS-1:0]   tag_ff, tag_in;
   logic [CNT_W-1:0]      i_ff, i_in;
   logic                  pend_ff, pend_in;
   logic [IDX_W-1:0]      pidx_ff, pidx_in;
   logic [IDX_W-1:0]      s_ff, s_in;
   logic [IDX_W-1:0]      old_ff, old_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [CNT_W-1:0]      nr_ff, nr_in;
   logic [CNT_W-1:0]      evicted_ff, evicted_in;
   logic                  walked_ff, walked_in;
   logic                  res_hit_ff, res_hit_in;
   logic                  res_fetch_ff, res_fetch_in;
   logic [IDX_W-1:0]      res_slot_ff, res_slot_in;
   status_type            res_status_ff, res_status_in;

   // response registers
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [IDX_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic                  rsp_fetch_ff, rsp_fetch_in;
   logic [CNT_W-1:0]      rsp_evicted_ff, rsp_evicted_in;
   logic [CNT_W-1:0]      rsp_cached_ff, rsp_cached_in;
   status_type            rsp_status_ff, rsp_status_in;

   // RAM ports
   logic                  ent_wr_en, ent_rd_en;
   logic [IDX_W-1:0]      ent_wr_addr, ent_rd_addr;
   logic [EW-1:0]         ent_wr_data, ent_wr_mask, ent_rd_data;
   logic                  ord_wr_en, ord_rd_en;
   logic [IDX_W-1:0]      ord_wr_addr, ord_rd_addr, ord_wr_data, ord_rd_data;

   logic [TAG_BITS-1:0]   ent_rd_tag;
   logic [IDX_W-1:0]      ent_rd_rank;
   logic [XW-1:0]         blk_ext;
   logic [IDX_W-1:0]      i_idx;
   logic                  issue_slot, issue_walk, issue_comp;
   logic                  look_match, slot_done, walk_done, comp_done;
   logic                  at_thr, has_room, rsp_free, req_fire, evictable;

   // entry RAM: {tag, rank} per slot
   bcl_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .wr_mask (ent_wr_mask),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   // order RAM: slot per rank, built for the eviction walk
   bcl_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_wr_en),
      .wr_addr (ord_wr_addr),
      .wr_data (ord_wr_data),
      .wr_mask ({IDX_W{1'b1}}),
      .rd_en   (ord_rd_en),
      .rd_addr (ord_rd_addr),
      .rd_data (ord_rd_data)
   );

   // condition terms
   assign ent_rd_tag  = ent_rd_data[EW-1:IDX_W];
   assign ent_rd_rank = ent_rd_data[IDX_W-1:0];
   assign blk_ext     = {{TAG_BITS{1'b0}}, req_block_no};
   assign i_idx       = i_ff[IDX_W-1:0];
   assign issue_slot  = i_ff < CAP_CNT;
   assign issue_walk  = i_ff != '0;
   assign issue_comp  = i_ff < n_ff;
   assign look_match  = pend_ff && valid_ff[pidx_ff] && (ent_rd_tag == tag_ff);
   assign slot_done   = !issue_slot && !pend_ff;
   assign walk_done   = !issue_walk && !pend_ff;
   assign comp_done   = !issue_comp && !pend_ff;
   assign at_thr      = CMP_W'(cnt_ff) >= CMP_W'(thr_ff);
   assign has_room    = cnt_ff < CAP_CNT;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign evictable   = valid_ff[ord_rd_data] && !pin_ff[ord_rd_data]
                        && !acq_ff[ord_rd_data];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_LOOK;
         end
         S_LOOK: begin
            if (look_match) begin
               state_in = (kind_ff == REQ_ACQUIRE) ? S_HIT_UPD : S_DONE;
            end else if (slot_done) begin
               if (kind_ff != REQ_ACQUIRE) state_in = S_DONE;
               else if (at_thr)            state_in = S_ORDER;
               else if (has_room)          state_in = S_FREE;
               else                        state_in = S_DONE;
            end
         end
         S_HIT_UPD: begin
            if (slot_done) state_in = S_DONE;
         end
         S_ORDER: begin
            if (slot_done) state_in = S_WALK;
         end
         S_WALK: begin
            if (walk_done) state_in = S_COMPACT;
         end
         S_COMPACT: begin
            if (comp_done) state_in = has_room ? S_FREE : S_DONE;
         end
         S_FREE: begin
            if (!valid_ff[i_idx]) state_in = walked_ff ? S_INSERT : S_INC;
         end
         S_INC: begin
            if (slot_done) state_in = S_INSERT;
         end
         S_INSERT: state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      valid_in       = valid_ff;
      acq_in         = acq_ff;
      pin_in         = pin_ff;
      cnt_in         = cnt_ff;
      kind_in        = kind_ff;
      tag_in         = tag_ff;
      i_in           = i_ff;
      pend_in        = 1'b0;
      pidx_in        = pidx_ff;
      s_in           = s_ff;
      old_in         = old_ff;
      n_in           = n_ff;
      nr_in          = nr_ff;
      evicted_in     = evicted_ff;
      walked_in      = walked_ff;
      res_hit_in     = res_hit_ff;
      res_fetch_in   = res_fetch_ff;
      res_slot_in    = res_slot_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_fetch_in   = rsp_fetch_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_cached_in  = rsp_cached_ff;
      rsp_status_in  = rsp_status_ff;
      ent_wr_en      = 1'b0;
      ent_wr_addr    = pidx_ff;
      ent_wr_data    = {ent_rd_tag, ent_rd_rank};
      ent_wr_mask    = RANK_MASK;
      ent_rd_en      = 1'b0;
      ent_rd_addr    = i_idx;
      ord_wr_en      = 1'b0;
      ord_wr_addr    = ent_rd_rank;
      ord_wr_data    = pidx_ff;
      ord_rd_en      = 1'b0;
      ord_rd_addr    = i_idx;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in       = req_kind_type'(req_type);
               tag_in        = blk_ext[TAG_BITS-1:0];
               i_in          = '0;
               evicted_in    = '0;
               walked_in     = 1'b0;
               res_hit_in    = 1'b0;
               res_fetch_in  = 1'b0;
               res_slot_in   = '0;
               res_status_in = STATUS_OK;
            end
         end

         // tag search, one slot per cycle
         S_LOOK: begin
            ent_rd_en = issue_slot;
            pend_in   = issue_slot;
            pidx_in   = i_idx;
            if (issue_slot) i_in = i_ff + 1'b1;
            if (look_match) begin
               pend_in     = 1'b0;
               i_in        = '0;
               s_in        = pidx_ff;
               old_in      = ent_rd_rank;
               res_hit_in  = 1'b1;
               res_slot_in = pidx_ff;
               unique case (kind_ff)
                  REQ_ACQUIRE: acq_in[pidx_ff] = 1'b1;
                  REQ_RELEASE: acq_in[pidx_ff] = 1'b0;
                  REQ_PIN:     pin_in[pidx_ff] = 1'b1;
                  REQ_UNPIN:   pin_in[pidx_ff] = 1'b0;
                  default:     acq_in = acq_ff;
               endcase
            end else if (slot_done) begin
               i_in = '0;
               if (kind_ff != REQ_ACQUIRE) begin
                  res_status_in = STATUS_NOT_CACHED;
               end else if (at_thr) begin
                  walked_in = 1'b1;
                  n_in      = cnt_ff;
               end else if (!has_room) begin
                  res_status_in = STATUS_NO_SLOT;
               end
            end
         end

         // hit: entry to rank 0, more recent entries move down one
         S_HIT_UPD: begin
            ent_rd_en = issue_slot;
            pend_in   = issue_slot;
            pidx_in   = i_idx;
            if (issue_slot) i_in = i_ff + 1'b1;
            if (pend_ff && valid_ff[pidx_ff]) begin
               if (pidx_ff == s_ff) begin
                  ent_wr_en   = 1'b1;
                  ent_wr_data = '0;
               end else if (ent_rd_rank < old_ff) begin
                  ent_wr_en   = 1'b1;
                  ent_wr_data = {ent_rd_tag, ent_rd_rank + IDX_W'(1)};
               end
            end
         end

         // build rank -> slot table
         S_ORDER: begin
            ent_rd_en = issue_slot;
            pend_in   = issue_slot;
            pidx_in   = i_idx;
            if (issue_slot) i_in = i_ff + 1'b1;
            if (pend_ff && valid_ff[pidx_ff]) ord_wr_en = 1'b1;
            if (slot_done) i_in = n_ff;
         end

         // walk from least recent, evict idle unpinned entries while at threshold
         S_WALK: begin
            ord_rd_en   = issue_walk;
            ord_rd_addr = IDX_W'(i_ff - 1'b1);
            pend_in     = issue_walk;
            if (issue_walk) i_in = i_ff - 1'b1;
            if (pend_ff && at_thr && evictable) begin
               valid_in[ord_rd_data] = 1'b0;
               cnt_in     = cnt_ff - 1'b1;
               evicted_in = evicted_ff + 1'b1;
            end
            if (walk_done) begin
               i_in  = '0;
               nr_in = '0;
            end
         end

         // dense re-rank of survivors, shifted by one if inserting
         S_COMPACT: begin
            ord_rd_en = issue_comp;
            pend_in   = issue_comp;
            if (issue_comp) i_in = i_ff + 1'b1;
            if (pend_ff && valid_ff[ord_rd_data]) begin
               ent_wr_en   = 1'b1;
               ent_wr_addr = ord_rd_data;
               ent_wr_data = {{TAG_BITS{1'b0}},
                              IDX_W'(nr_ff + CNT_W'(has_room))};
               nr_in       = nr_ff + 1'b1;
            end
            if (comp_done) begin
               i_in = '0;
               if (!has_room) res_status_in = STATUS_NO_SLOT;
            end
         end

         // lowest free slot
         S_FREE: begin
            if (!valid_ff[i_idx]) begin
               s_in = i_idx;
               i_in = '0;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end

         // age every valid entry by one
         S_INC: begin
            ent_rd_en = issue_slot;
            pend_in   = issue_slot;
            pidx_in   = i_idx;
            if (issue_slot) i_in = i_ff + 1'b1;
            if (pend_ff && valid_ff[pidx_ff]) begin
               ent_wr_en   = 1'b1;
               ent_wr_data = {ent_rd_tag, ent_rd_rank + IDX_W'(1)};
            end
         end

         S_INSERT: begin
            ent_wr_en     = 1'b1;
            ent_wr_addr   = s_ff;
            ent_wr_data   = {tag_ff, {IDX_W{1'b0}}};
            ent_wr_mask   = FULL_MASK;
            valid_in[s_ff] = 1'b1;
            acq_in[s_ff]   = 1'b1;
            pin_in[s_ff]   = 1'b0;
            cnt_in        = cnt_ff + 1'b1;
            res_slot_in   = s_ff;
            res_fetch_in  = 1'b1;
         end

         // hand the result to the output register
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = res_hit_ff;
               rsp_slot_in    = res_slot_ff;
               rsp_fetch_in   = res_fetch_ff;
               rsp_evicted_in = evicted_ff;
               rsp_cached_in  = cnt_ff;
               rsp_status_in  = res_status_ff;
            end
         end

         default: pend_in = 1'b0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= THR_RESET;
         valid_ff     <= '0;
         acq_ff       <= '0;
         pin_ff       <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) thr_ff <= csr_wr_data;
         valid_ff     <= valid_in;
         acq_ff       <= acq_in;
         pin_ff       <= pin_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      tag_ff         <= tag_in;
      i_ff           <= i_in;
      pidx_ff        <= pidx_in;
      s_ff           <= s_in;
      old_ff         <= old_in;
      n_ff           <= n_in;
      nr_ff          <= nr_in;
      evicted_ff     <= evicted_in;
      walked_ff      <= walked_in;
      res_hit_ff     <= res_hit_in;
      res_fetch_ff   <= res_fetch_in;
      res_slot_ff    <= res_slot_in;
      res_status_ff  <= res_status_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_fetch_ff   <= rsp_fetch_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_cached_ff  <= rsp_cached_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_fetch_needed  = rsp_fetch_ff;
   assign rsp_evicted_count = rsp_evicted_ff;
   assign rsp_cached_count  = rsp_cached_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

[bench/bcl_checker.sv]
// ----------------------------------------------------------------------------
// bcl_checker
// Watches the request, response and CSR ports of the block cache, keeps its
// own copy of the LRU tag table, predicts each response and compares them.
// ----------------------------------------------------------------------------
module bcl_checker
   import bcl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [BLOCK_W-1:0] req_block_no,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_hit,
   input  logic [5:0]         rsp_slot,
   input  logic               rsp_fetch_needed,
   input  logic [6:0]         rsp_evicted_count,
   input  logic [6:0]         rsp_cached_count,
   input  logic [1:0]         rsp_status,
   input  logic               csr_wr_en,
   input  logic [THR_W-1:0]   csr_wr_data,
   output int                 fail_count,
   output int                 pending
);

   localparam int DEPTH = 64;

   typedef struct packed {
      logic       hit;
      logic [5:0] slot;
      logic       fetch;
      logic [6:0] evicted;
      logic [6:0] cached;
      logic [1:0] status;
   } cache_rsp_type;

   // shadow tag table
   logic [31:0]      tag_tbl [DEPTH];
   logic             live    [DEPTH];
   logic             held    [DEPTH];
   logic             pinned  [DEPTH];
   int               rank    [DEPTH];
   int               live_cnt;
   logic [THR_W-1:0] evict_thr;

   cache_rsp_type rsp_queue[$];

   assign pending = rsp_queue.size();

   // apply one request to the shadow table, return its response
   task automatic serve_request(input logic [1:0] kind, input logic [31:0] blk,
                                output cache_rsp_type res);
      int found;
      int old;
      int nr;
      int e;
      int ord [DEPTH];
      found = -1;
      res   = '0;
      for (int i = 0; i < DEPTH; i++)
         if (found < 0 && live[i] && tag_tbl[i] == blk) found = i;
      if (kind == REQ_ACQUIRE) begin
         if (found >= 0) begin
            old = rank[found];
            for (int i = 0; i < DEPTH; i++)
               if (live[i] && rank[i] < old) rank[i]++;
            rank[found]  = 0;
            held[found]  = 1'b1;
            res.hit      = 1'b1;
            res.slot     = found[5:0];
         end else begin
            // eviction walk from least recent
            if (live_cnt >= int'(evict_thr)) begin
               for (int i = 0; i < DEPTH; i++) ord[i] = -1;
               for (int i = 0; i < DEPTH; i++)
                  if (live[i] && rank[i] < DEPTH) ord[rank[i]] = i;
               for (int r = DEPTH-1; r >= 0; r--) begin
                  e = ord[r];
                  if (live_cnt < int'(evict_thr)) break;
                  if (e >= 0 && !pinned[e] && !held[e]) begin
                     live[e] = 1'b0;
                     live_cnt--;
                     res.evicted++;
                  end
               end
               nr = 0;
               for (int r = 0; r < DEPTH; r++) begin
                  e = ord[r];
                  if (e >= 0 && live[e]) begin
                     rank[e] = nr;
                     nr++;
                  end
               end
            end
            found = -1;
            for (int i = 0; i < DEPTH; i++)
               if (found < 0 && !live[i]) found = i;
            if (found < 0) begin
               res.status = STATUS_NO_SLOT;
            end else begin
               for (int i = 0; i < DEPTH; i++)
                  if (live[i]) rank[i]++;
               tag_tbl[found] = blk;
               live[found]    = 1'b1;
               held[found]    = 1'b1;
               pinned[found]  = 1'b0;
               rank[found]    = 0;
               live_cnt++;
               res.slot  = found[5:0];
               res.fetch = 1'b1;
            end
         end
      end else if (found < 0) begin
         res.status = STATUS_NOT_CACHED;
      end else begin
         case (kind)
            REQ_RELEASE: held[found]   = 1'b0;
            REQ_PIN:     pinned[found] = 1'b1;
            default:     pinned[found] = 1'b0;
         endcase
         res.hit  = 1'b1;
         res.slot = found[5:0];
      end
      res.cached = live_cnt[6:0];
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   // follow every transfer on the three ports
   always @(posedge clock) begin
      cache_rsp_type pred;
      cache_rsp_type want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            live[i]   = 1'b0;
            held[i]   = 1'b0;
            pinned[i] = 1'b0;
            rank[i]   = 0;
         end
         live_cnt  = 0;
         evict_thr = THR_RESET;
         rsp_queue.delete();
      end else begin
         if (csr_wr_en) evict_thr = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (rsp_queue.size() == 0) begin
               report_mismatch("outstanding responses", 1, 0);
            end else begin
               want = rsp_queue.pop_front();
               if (rsp_hit != want.hit) report_mismatch("hit", rsp_hit, want.hit);
               if (rsp_slot != want.slot) report_mismatch("slot", rsp_slot, want.slot);
               if (rsp_fetch_needed != want.fetch)
                  report_mismatch("fetch_needed", rsp_fetch_needed, want.fetch);
               if (rsp_evicted_count != want.evicted)
                  report_mismatch("evicted_count", rsp_evicted_count, want.evicted);
               if (rsp_cached_count != want.cached)
                  report_mismatch("cached_count", rsp_cached_count, want.cached);
               if (rsp_status != want.status)
                  report_mismatch("status", rsp_status, want.status);
            end
         end
         if (req_valid && req_ready) begin
            serve_request(req_type, req_block_no, pred);
            rsp_queue.push_back(pred);
         end
      end
   end

   initial fail_count = 0;

endmodule

[bench/tb_block_cache_lru_evict.sv]
// ----------------------------------------------------------------------------
// tb_block_cache_lru_evict
// Drives acquire / release / pin / unpin traffic into the block cache over
// several eviction thresholds, with random stalls on both sides; a checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_block_cache_lru_evict;
   import bcl_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int PHASE_LEN  = 210;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_type;
   logic [BLOCK_W-1:0] req_block_no;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_hit;
   logic [5:0]         rsp_slot;
   logic               rsp_fetch_needed;
   logic [6:0]         rsp_evicted_count;
   logic [6:0]         rsp_cached_count;
   logic [1:0]         rsp_status;
   logic               csr_wr_en;
   logic [THR_W-1:0]   csr_wr_data;
   int                 fail_count;
   int                 pending;
   logic               calm;
   int                 stall_left = 0;
   int                 idle_cycles = 0;
   logic [31:0]        block_pool [96];

   block_cache_lru_evict i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_block_no     (req_block_no),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_slot         (rsp_slot),
      .rsp_fetch_needed (rsp_fetch_needed),
      .rsp_evicted_count(rsp_evicted_count),
      .rsp_cached_count (rsp_cached_count),
      .rsp_status       (rsp_status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   bcl_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // response side stalls in bursts of random length
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // one request transfer, with an optional gap before it
   task automatic send_req(input req_kind_type kind, input logic [31:0] blk);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_block_no <= blk;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_thr(input logic [THR_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // mostly pool blocks so hits and evictions happen, some fully random
   task automatic send_random();
      int pick;
      logic [31:0] blk;
      req_kind_type kind;
      pick = $urandom_range(0, 99);
      if (pick < 50) kind = REQ_ACQUIRE;
      else if (pick < 80) kind = REQ_RELEASE;
      else if (pick < 90) kind = REQ_PIN;
      else kind = REQ_UNPIN;
      if ($urandom_range(0, 19) == 0) blk = $urandom;
      else blk = block_pool[$urandom_range(0, 95)];
      send_req(kind, blk);
   endtask

   initial begin
      logic [THR_W-1:0] thr_list [8];
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_type     <= REQ_ACQUIRE;
      req_block_no <= '0;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      calm         <= 1'b0;
      thr_list = '{7'd32, 7'd4, 7'd0, 7'd64, 7'd127, 7'd1, 7'd16, 7'd63};
      block_pool[0] = 32'h0;
      block_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 96; i++) block_pool[i] = $urandom;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, hits, every request kind on cached and uncached
      send_req(REQ_ACQUIRE, 32'h0);
      send_req(REQ_ACQUIRE, 32'hFFFF_FFFF);
      send_req(REQ_ACQUIRE, 32'h0);
      send_req(REQ_RELEASE, 32'h0);
      send_req(REQ_PIN,     32'hFFFF_FFFF);
      send_req(REQ_RELEASE, 32'hFFFF_FFFF);
      send_req(REQ_ACQUIRE, 32'hFFFF_FFFF);
      send_req(REQ_UNPIN,   32'hFFFF_FFFF);
      send_req(REQ_RELEASE, 32'h1234_5678);
      send_req(REQ_PIN,     32'h1234_5678);
      send_req(REQ_UNPIN,   32'h1234_5678);
      write_thr(7'd2);
      send_req(REQ_RELEASE, 32'hFFFF_FFFF);
      send_req(REQ_ACQUIRE, 32'h5555_AAAA);
      send_req(REQ_RELEASE, 32'h5555_AAAA);
      send_req(REQ_ACQUIRE, 32'hAAAA_5555);
      send_req(REQ_ACQUIRE, 32'h8000_0001);
      write_thr(7'd127);
      for (int i = 0; i < 8; i++) send_req(REQ_ACQUIRE, 32'h100 + i);

      // random phases over several thresholds
      for (int p = 0; p < 8; p++) begin
         write_thr(thr_list[p]);
         if (p == 7) calm <= 1'b1;
         for (int n = 0; n < PHASE_LEN; n++) begin
            if (p == 3 && n == PHASE_LEN / 2) drain();
            send_random();
         end
      end

      drain();
      repeat (500) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
